### design/kpe_pkg.sv
// Shared types and constants for the k-mer position extractor.
package kpe_pkg;

	// Field widths
	localparam int CHAR_W = 8;
	localparam int CODE_W = 32;
	localparam int POS_W  = 32;
	localparam int RUN_W  = 5;
	localparam int MAX_K  = 16;

	// Input word kinds
	localparam logic FUNC_CHAR   = 1'b0;
	localparam logic FUNC_CONTIG = 1'b1;

	// Register map (word index)
	localparam logic REG_BISULFITE = 1'b0;

	// Character codes
	localparam logic [CHAR_W-1:0] CH_UA   = 8'h41;
	localparam logic [CHAR_W-1:0] CH_UZ   = 8'h5A;
	localparam logic [CHAR_W-1:0] CH_LA   = 8'h61;
	localparam logic [CHAR_W-1:0] CH_LZ   = 8'h7A;
	localparam logic [CHAR_W-1:0] CH_N    = 8'h4E;
	localparam logic [CHAR_W-1:0] CH_C    = 8'h43;
	localparam logic [CHAR_W-1:0] CH_G    = 8'h47;
	localparam logic [CHAR_W-1:0] CH_T    = 8'h54;
	localparam logic [CHAR_W-1:0] CASE_BIT = 8'h20;

	// Base codes
	localparam logic [1:0] BASE_A = 2'd0;
	localparam logic [1:0] BASE_C = 2'd1;
	localparam logic [1:0] BASE_G = 2'd2;
	localparam logic [1:0] BASE_T = 2'd3;

	// Rolling state
	typedef struct packed {
		logic [CODE_W-1:0] kmer;
		logic [RUN_W-1:0]  run;
		logic [POS_W-1:0]  pos;
	} kpe_state_t;

	// One result word
	typedef struct packed {
		logic              char_valid;
		logic [CHAR_W-1:0] char_out;
		logic              kmer_valid;
		logic [CODE_W-1:0] kmer_code;
		logic [POS_W-1:0]  kmer_position;
	} kpe_result_t;

endpackage

### design/kpe_encode.sv
// Combinational step: next rolling state and result word for one input word.
module kpe_encode #(
	parameter int KLEN = 16
) (
	input  logic                        func,
	input  logic [kpe_pkg::CHAR_W-1:0]  char_in,
	input  logic                        bisulfite,
	input  kpe_pkg::kpe_state_t         cur,
	output kpe_pkg::kpe_state_t         nxt,
	output kpe_pkg::kpe_result_t        res
);

	localparam logic [kpe_pkg::CODE_W:0] MASK_W =
		(({{kpe_pkg::CODE_W{1'b0}}, 1'b1}) << (2 * KLEN)) - 1;
	localparam logic [kpe_pkg::CODE_W-1:0] KMASK = MASK_W[kpe_pkg::CODE_W-1:0];
	localparam logic [kpe_pkg::RUN_W-1:0]  K_RUN = kpe_pkg::RUN_W'(KLEN);
	localparam logic [kpe_pkg::POS_W-1:0]  K_BACK = kpe_pkg::POS_W'(KLEN - 1);

	logic                       is_upper;
	logic                       is_lower;
	logic [kpe_pkg::CHAR_W-1:0] up_char;
	logic [1:0]                 base;
	logic [kpe_pkg::CODE_W-1:0] shifted;
	logic [kpe_pkg::RUN_W-1:0]  run_inc;

	// Letter classification and upper-casing
	assign is_upper = (char_in >= kpe_pkg::CH_UA) && (char_in <= kpe_pkg::CH_UZ);
	assign is_lower = (char_in >= kpe_pkg::CH_LA) && (char_in <= kpe_pkg::CH_LZ);
	assign up_char  = is_lower ? (char_in & ~kpe_pkg::CASE_BIT) : char_in;

	// 2-bit base code
	always_comb begin
		case (up_char)
			kpe_pkg::CH_C: base = bisulfite ? kpe_pkg::BASE_T : kpe_pkg::BASE_C;
			kpe_pkg::CH_G: base = kpe_pkg::BASE_G;
			kpe_pkg::CH_T: base = kpe_pkg::BASE_T;
			default:       base = kpe_pkg::BASE_A;
		endcase
	end

	assign shifted = {cur.kmer[kpe_pkg::CODE_W-3:0], base} & KMASK;
	assign run_inc = (cur.run < K_RUN) ? cur.run + 1'b1 : cur.run;

	// State update and result
	always_comb begin
		nxt = cur;
		res = '0;
		if (func == kpe_pkg::FUNC_CONTIG) begin
			nxt.kmer = '0;
			nxt.run  = '0;
			nxt.pos  = cur.pos - K_BACK;
		end else if (is_upper || is_lower) begin
			res.char_valid = 1'b1;
			res.char_out   = up_char;
			nxt.pos        = cur.pos + 1'b1;
			if (up_char == kpe_pkg::CH_N) begin
				nxt.kmer = '0;
				nxt.run  = '0;
			end else begin
				nxt.kmer = shifted;
				nxt.run  = run_inc;
				if (run_inc >= K_RUN) begin
					res.kmer_valid    = 1'b1;
					res.kmer_code     = shifted;
					res.kmer_position = cur.pos;
				end
			end
		end
	end

endmodule

### design/kmer_position_extractor_top.sv
// Top level of the rolling 2-bit k-mer encoder with genome positions.
// One sequence character or contig-start word is taken per cycle while in_ready
// is high; its result word, from the combinational state update (shift, run
// counter, position add), appears in the output register on the next cycle.
// in_ready stays high while the output register is empty or being drained.
// bisulfite_mode sits at byte address 0 of the APB port and must be written
// only while the block is idle.
module kmer_position_extractor_top #(
	parameter int KMER_LEN = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// input channel
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        func,
	input  logic [kpe_pkg::CHAR_W-1:0]  char_in,
	// output channel
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        char_valid,
	output logic [kpe_pkg::CHAR_W-1:0]  char_out,
	output logic                        kmer_valid,
	output logic [kpe_pkg::CODE_W-1:0]  kmer_code,
	output logic [kpe_pkg::POS_W-1:0]   kmer_position,
	// configuration port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [2:0]                  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);

	localparam int KLEN = (KMER_LEN < 1) ? 1 :
		((KMER_LEN > kpe_pkg::MAX_K) ? kpe_pkg::MAX_K : KMER_LEN);

	logic                 bisulfite_q;
	kpe_pkg::kpe_state_t  state_q;
	kpe_pkg::kpe_state_t  state_nxt;
	kpe_pkg::kpe_result_t res_nxt;
	kpe_pkg::kpe_result_t res_q;
	logic                 out_valid_q;
	logic                 take;

	// Configuration register
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bisulfite_q <= 1'b0;
		end else if (psel && penable && pwrite && (paddr[2] == kpe_pkg::REG_BISULFITE)) begin
			bisulfite_q <= pwdata[0];
		end
	end
	assign prdata = (paddr[2] == kpe_pkg::REG_BISULFITE) ? {31'd0, bisulfite_q} : '0;

	// Handshake
	assign in_ready = !out_valid_q || out_ready;
	assign take     = in_valid && in_ready;

	kpe_encode #(
		.KLEN(KLEN)
	) u_encode (
		.func      (func),
		.char_in   (char_in),
		.bisulfite (bisulfite_q),
		.cur       (state_q),
		.nxt       (state_nxt),
		.res       (res_nxt)
	);

	// Rolling state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				state_q <= state_nxt;
			end
			if (take) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result word register
	always_ff @(posedge clk) begin
		if (take) begin
			res_q <= res_nxt;
		end
	end

	assign out_valid     = out_valid_q;
	assign char_valid    = res_q.char_valid;
	assign char_out      = res_q.char_out;
	assign kmer_valid    = res_q.kmer_valid;
	assign kmer_code     = res_q.kmer_code;
	assign kmer_position = res_q.kmer_position;

endmodule

### sim/kmer_position_extractor_top_test.sv
`timescale 1ns / 100ps
// Testbench for the k-mer position extractor: directed and random words checked against a predictor.
module kmer_position_extractor_top_test;
	localparam int KLEN  = kpe_pkg::MAX_K;
	localparam int LIMIT = 200000;
	localparam logic [kpe_pkg::CHAR_W-1:0] BASES [4] =
		'{kpe_pkg::CH_UA, kpe_pkg::CH_C, kpe_pkg::CH_G, kpe_pkg::CH_T};

	// Tracks the rolling k-mer state and holds the result words still due from the block
	class kmer_tracker;
		logic [kpe_pkg::CODE_W-1:0] kmer;
		logic [kpe_pkg::RUN_W-1:0]  run;
		logic [kpe_pkg::POS_W-1:0]  pos;
		logic                       bisulfite;
		kpe_pkg::kpe_result_t       due_words[$];
		int                         errors;
		int                         n_words;
		int                         n_kmers;
		int                         n_contigs;

		function new();
			kmer = '0;
			run = '0;
			pos = '0;
			bisulfite = 1'b0;
			errors = 0;
			n_words = 0;
			n_kmers = 0;
			n_contigs = 0;
		endfunction

		// Advance the rolling state for one accepted word and queue its result
		function void note_word(logic f, logic [kpe_pkg::CHAR_W-1:0] c);
			kpe_pkg::kpe_result_t       want;
			logic [kpe_pkg::CHAR_W-1:0] up;
			logic [1:0]                 code;
			logic [63:0]                span;
			want = '0;
			span = (64'd1 << (2 * KLEN)) - 64'd1;
			n_words++;
			if (f == kpe_pkg::FUNC_CONTIG) begin
				// new contig: clear the k-mer, pull the position back by K-1
				kmer = '0;
				run = '0;
				pos = pos - 32'(KLEN - 1);
				n_contigs++;
			end else if ((c >= kpe_pkg::CH_UA && c <= kpe_pkg::CH_UZ) ||
				(c >= kpe_pkg::CH_LA && c <= kpe_pkg::CH_LZ)) begin
				up = c & ~kpe_pkg::CASE_BIT;
				want.char_valid = 1'b1;
				want.char_out = up;
				if (up == kpe_pkg::CH_N) begin
					kmer = '0;
					run = '0;
				end else begin
					if (up == kpe_pkg::CH_C)
						code = bisulfite ? kpe_pkg::BASE_T : kpe_pkg::BASE_C;
					else if (up == kpe_pkg::CH_G) code = kpe_pkg::BASE_G;
					else if (up == kpe_pkg::CH_T) code = kpe_pkg::BASE_T;
					else code = kpe_pkg::BASE_A;
					kmer = ((kmer << 2) | {30'd0, code}) & span[31:0];
					if (run < KLEN) run++;
					if (run >= KLEN) begin
						want.kmer_valid = 1'b1;
						want.kmer_code = kmer;
						want.kmer_position = pos;
						n_kmers++;
					end
				end
				// every letter moves the position, N included
				pos = pos + 32'd1;
			end
			due_words.push_back(want);
		endfunction

		task report(string msg);
			errors++;
			$display("[%0t] %s", $time, msg);
		endtask

		task cmp_field(string name, logic [31:0] got, logic [31:0] want);
			if (got !== want)
				report($sformatf("%s: got %h, want %h (word %0d)", name, got, want,
					n_words - due_words.size()));
		endtask

		// Compare one accepted result word with the oldest one due
		task check_word(kpe_pkg::kpe_result_t got);
			kpe_pkg::kpe_result_t want;
			if (due_words.size() == 0) begin
				report($sformatf("result word with none due: char %h kmer %h pos %h",
					got.char_out, got.kmer_code, got.kmer_position));
				return;
			end
			want = due_words.pop_front();
			cmp_field("char_valid", 32'(got.char_valid), 32'(want.char_valid));
			cmp_field("char_out", 32'(got.char_out), 32'(want.char_out));
			cmp_field("kmer_valid", 32'(got.kmer_valid), 32'(want.kmer_valid));
			cmp_field("kmer_code", got.kmer_code, want.kmer_code);
			cmp_field("kmer_position", got.kmer_position, want.kmer_position);
		endtask
	endclass

	logic                       clk;
	logic                       arst_n;
	logic                       in_valid;
	logic                       in_ready;
	logic                       func;
	logic [kpe_pkg::CHAR_W-1:0] char_in;
	logic                       out_valid;
	logic                       out_ready;
	logic                       char_valid;
	logic [kpe_pkg::CHAR_W-1:0] char_out;
	logic                       kmer_valid;
	logic [kpe_pkg::CODE_W-1:0] kmer_code;
	logic [kpe_pkg::POS_W-1:0]  kmer_position;
	logic                       psel;
	logic                       penable;
	logic                       pwrite;
	logic [2:0]                 paddr;
	logic [31:0]                pwdata;
	logic [31:0]                prdata;
	logic                       pready;

	kmer_tracker sb = new();

	kmer_position_extractor_top #(.KMER_LEN(KLEN)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.func(func),
		.char_in(char_in),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.char_valid(char_valid),
		.char_out(char_out),
		.kmer_valid(kmer_valid),
		.kmer_code(kmer_code),
		.kmer_position(kmer_position),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// 10 ns clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Offer one word after a random gap; returns at the edge that accepts it
	task automatic send_word(input logic f, input logic [kpe_pkg::CHAR_W-1:0] c,
		input bit quiet);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		char_in <= c;
		do @(posedge clk); while (!in_ready);
		sb.note_word(f, c);
	endtask

	// Stop offering and wait until every due word has come back
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.due_words.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_bisulfite(input logic v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {kpe_pkg::REG_BISULFITE, 2'b00};
		pwdata <= {31'd0, v};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.bisulfite = v;
	endtask

	// Mostly base letters of random case, with N, contig starts, other letters and raw bytes
	task automatic random_words(input int count, input bit with_pause);
		int                         pick;
		bit                         quiet;
		logic [kpe_pkg::CHAR_W-1:0] c;
		logic [kpe_pkg::CHAR_W-1:0] lower;
		for (int i = 0; i < count; i++) begin
			quiet = ((i / 40) % 4) == 3;
			if (with_pause && i == count / 2) drain();
			pick = $urandom_range(0, 99);
			lower = $urandom_range(0, 1) ? kpe_pkg::CASE_BIT : 8'h00;
			if (pick < 3) c = 8'($urandom);
			else if (pick < 7) c = kpe_pkg::CH_N | lower;
			else if (pick < 13) c = 8'($urandom);
			else if (pick < 18) c = (kpe_pkg::CH_UA + 8'($urandom_range(0, 25))) | lower;
			else c = BASES[$urandom_range(0, 3)] | lower;
			send_word(pick < 3 ? kpe_pkg::FUNC_CONTIG : kpe_pkg::FUNC_CHAR, c, quiet);
		end
	endtask

	// Result side: random stalls, long hold-offs that back up the input, quiet stretches
	initial begin : result_side
		int gap;
		int taken;
		taken = 0;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (taken == 150 || taken == 600) gap = 80;
			else if ((taken / 50) % 3 == 2) gap = 0;
			else gap = $urandom_range(0, 13);
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			sb.check_word('{char_valid, char_out, kmer_valid, kmer_code, kmer_position});
			taken++;
		end
	end

	// Watchdog
	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Timeout after %0d cycles, %0d words still due", cycles, sb.due_words.size());
		$display("Mismatches found");
		$finish;
	end

	// Word side: reset, register settings, directed then random words
	initial begin : word_side
		logic [kpe_pkg::CHAR_W-1:0] probe [27];
		probe = '{8'h00, 8'hFF, 8'h80, 8'h40, 8'h5B, 8'h60, 8'h7B, "N", "n",
			"A", "c", "G", "t", "Z", "z", "a", "C", "g", "T", "b", "y",
			"C", "G", "T", "A", "c", "g"};
		arst_n = 1'b0;
		in_valid = 1'b0;
		func = kpe_pkg::FUNC_CHAR;
		char_in = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_bisulfite(1'b0);

		// contig start right after reset wraps the position below zero
		send_word(kpe_pkg::FUNC_CONTIG, 8'hFF, 1'b0);
		// non-letter edges, N in both cases, then a run long enough for k-mers
		foreach (probe[i]) send_word(kpe_pkg::FUNC_CHAR, probe[i], 1'b0);

		random_words(300, 1'b1);
		drain();
		write_bisulfite(1'b1);
		random_words(280, 1'b0);
		drain();
		write_bisulfite(1'b0);
		random_words(250, 1'b0);
		drain();

		$display("Ran %0d words with %0d contig starts and %0d k-mers reported,",
			sb.n_words, sb.n_contigs, sb.n_kmers);
		$display("with bisulfite mode off and on and output hold-offs backing up the input.");
		if (sb.errors == 0 && sb.due_words.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end
endmodule
